// File: design/password_hiding_engine_top_assert.svh
// Assertion macros used by the password hiding engine top module.
`ifndef PASSWORD_HIDING_ENGINE_TOP_ASSERT_SVH
`define PASSWORD_HIDING_ENGINE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PHE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PHE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: design/phe_pkg.sv
// Package with MD5 constants and shared types for the password hiding engine.
`timescale 1ns / 1ps
package phe_pkg;
    localparam int BLOCK_BYTES = 16;
    localparam int SECRET_BYTES_HW = 32;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_SECRET_0 = 3'd0;
    localparam logic [2:0] REG_SECRET_1 = 3'd1;
    localparam logic [2:0] REG_SECRET_2 = 3'd2;
    localparam logic [2:0] REG_SECRET_3 = 3'd3;
    localparam logic [2:0] REG_SECLEN   = 3'd4;
    localparam logic [2:0] REG_AUTH_HI  = 3'd5;
    localparam logic [2:0] REG_AUTH_LO  = 3'd6;

    typedef logic [31:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HASH = 4'b0010,
        ST_OUT  = 4'b0100,
        ST_PAD  = 4'b1000
    } state_t;

    function automatic word_t md5_k(input logic [5:0] i);
        word_t k;
        unique case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction
endpackage

// File: design/phe_md5_core.sv
// Iterative MD5 compression: one round per cycle over a 512-bit message block.
`timescale 1ns / 1ps
module phe_md5_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [511:0] msg,
    output logic         done,
    output logic [127:0] digest
);
    logic [511:0] msg_reg;
    phe_pkg::word_t a_reg, b_reg, c_reg, d_reg;
    phe_pkg::word_t a_next, b_next, c_next, d_next;
    logic [5:0] round_count_reg;
    logic       run_reg;
    logic       done_reg;
    logic [127:0] digest_reg;
    phe_pkg::word_t f_val, t_val, m_val, rot_val;
    logic [3:0] g_idx;
    logic [4:0] sh;
    logic [5:0] r5, r3, r7;

    always_comb begin
        r5 = 6'(5 * round_count_reg + 1);
        r3 = 6'(3 * round_count_reg + 5);
        r7 = 6'(7 * round_count_reg);
        unique case (round_count_reg[5:4])
            2'd0: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = round_count_reg[3:0];
            end
            2'd1: begin
                f_val = (d_reg & b_reg) | (~d_reg & c_reg);
                g_idx = r5[3:0];
            end
            2'd2: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = r3[3:0];
            end
            default: begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = r7[3:0];
            end
        endcase
        m_val   = msg_reg[g_idx*32 +: 32];
        t_val   = f_val + a_reg + phe_pkg::md5_k(round_count_reg) + m_val;
        sh      = phe_pkg::md5_s(round_count_reg);
        rot_val = (t_val << sh) | (t_val >> (6'd32 - {1'b0, sh}));
        a_next  = d_reg;
        d_next  = c_reg;
        c_next  = b_reg;
        b_next  = b_reg + rot_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg         <= 1'b0;
            done_reg        <= 1'b0;
            round_count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg         <= 1'b1;
                round_count_reg <= '0;
            end else if (run_reg) begin
                round_count_reg <= round_count_reg + 6'd1;
                if (round_count_reg == 6'd63) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            msg_reg <= msg;
            a_reg <= 32'h67452301;
            b_reg <= 32'hefcdab89;
            c_reg <= 32'h98badcfe;
            d_reg <= 32'h10325476;
        end else if (run_reg) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            if (round_count_reg == 6'd63) begin
                digest_reg <= {32'h10325476 + d_next, 32'h98badcfe + c_next,
                               32'hefcdab89 + b_next, 32'h67452301 + a_next};
            end
        end
    end

    assign done   = done_reg;
    assign digest = digest_reg;
endmodule

// File: design/password_hiding_engine_top.sv
// Top level of the password hiding engine: sequencer, chain state and output register.
`timescale 1ns / 1ps
// Flow: a byte at block position 0 goes through ST_HASH (a full MD5 compression), then ST_OUT;
//   other bytes go from ST_IDLE straight to ST_OUT. Pad items follow one per cycle while m_ready holds.
// The engine takes no new item until the current item and its pad items have all left.
// Reset (aresetn low, synchronous): config registers, chain and position clear to zero.
module password_hiding_engine_top #(
    parameter int SECRET_MAX_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_plain_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_hidden_byte,
    output logic        m_pad_flag,
    output logic        m_end_flag
);
    // Secret bytes beyond the 32 stored ones read as zero up to this length.
    localparam int CLAMP = SECRET_MAX_BYTES;

    logic [255:0] secret_reg;
    logic [5:0]   secret_length_reg;
    logic [127:0] auth_reg;

    logic [127:0] chain_reg, chain_next;
    logic [127:0] key_digest_reg, key_digest_next;
    logic [127:0] collect_reg, collect_next;
    logic [3:0]   pos_reg, pos_next;
    logic         busy_reg, busy_next;
    logic         last_reg, last_next;
    logic [7:0]   byte_reg, byte_next;
    phe_pkg::state_t state_reg, state_next;

    logic         ov_reg, ov_next;
    logic [7:0]   ohid_reg, ohid_next;
    logic         opad_reg, opad_next;
    logic         oend_reg, oend_next;

    logic         hash_start;
    logic         hash_done;
    logic [127:0] hash_digest;
    logic [127:0] hash_chain;
    logic [511:0] msg;
    logic [5:0]   len;
    logic [7:0]   cbyte;
    logic [3:0]   pos_inc;

    // Configuration writes; unknown indexes drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_reg        <= '0;
            secret_length_reg <= '0;
            auth_reg          <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                phe_pkg::REG_SECRET_0: secret_reg[255:192] <= cfg_data;
                phe_pkg::REG_SECRET_1: secret_reg[191:128] <= cfg_data;
                phe_pkg::REG_SECRET_2: secret_reg[127:64]  <= cfg_data;
                phe_pkg::REG_SECRET_3: secret_reg[63:0]    <= cfg_data;
                phe_pkg::REG_SECLEN:   secret_length_reg   <= cfg_data[5:0];
                phe_pkg::REG_AUTH_HI:  auth_reg[127:64]    <= cfg_data;
                phe_pkg::REG_AUTH_LO:  auth_reg[63:0]      <= cfg_data;
                default: ;
            endcase
        end
    end

    // First block of a password chains on the authenticator as it stands now.
    assign hash_chain = busy_reg ? chain_reg : auth_reg;

    // Build the MD5 block: secret, chain, 0x80, bit length. Byte n of msg at bits 8n.
    always_comb begin
        len = (secret_length_reg > 6'(CLAMP)) ? 6'(CLAMP) : secret_length_reg;
        msg = '0;
        for (int i = 0; i < 32; i++) begin
            if (6'(i) < len) msg[i*8 +: 8] = secret_reg[255 - i*8 -: 8];
        end
        for (int i = 0; i < 16; i++) begin
            msg[(32'(len) + i)*8 +: 8] = hash_chain[127 - i*8 -: 8];
        end
        msg[(32'(len) + 16)*8 +: 8] = 8'h80;
        msg[455:448] = 8'({len, 3'b000} + 9'd128);
        msg[463:456] = {7'd0, (9'({len, 3'b000}) + 9'd128) > 9'd255};
    end

    // Hidden byte: input byte XOR digest byte at the current position; digest byte n sits at bits 8n.
    assign cbyte   = byte_reg ^ key_digest_reg[pos_reg*8 +: 8];
    assign pos_inc = pos_reg + 4'd1;
    assign s_ready = (state_reg == phe_pkg::ST_IDLE) && !ov_reg;

    always_comb begin
        state_next      = state_reg;
        chain_next      = chain_reg;
        key_digest_next = key_digest_reg;
        collect_next    = collect_reg;
        pos_next        = pos_reg;
        busy_next       = busy_reg;
        last_next       = last_reg;
        byte_next       = byte_reg;
        ov_next         = ov_reg && !m_ready;
        ohid_next       = ohid_reg;
        opad_next       = opad_reg;
        oend_next       = oend_reg;
        hash_start      = 1'b0;
        unique case (state_reg)
            phe_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    byte_next = s_plain_byte;
                    last_next = s_last_byte;
                    busy_next = 1'b1;
                    // Start of a password: reload chain from the authenticator.
                    if (!busy_reg) begin
                        chain_next = auth_reg;
                        pos_next   = '0;
                    end
                    if (!busy_reg || pos_reg == 4'd0) begin
                        state_next = phe_pkg::ST_HASH;
                        hash_start = 1'b1;
                    end else begin
                        state_next = phe_pkg::ST_OUT;
                    end
                end
            end
            phe_pkg::ST_HASH: begin
                if (hash_done) begin
                    key_digest_next = hash_digest;
                    state_next      = phe_pkg::ST_OUT;
                end
            end
            phe_pkg::ST_OUT, phe_pkg::ST_PAD: begin
                // Emit one item when the output register is free or its item is being taken.
                if (!ov_reg || m_ready) begin
                    ov_next   = 1'b1;
                    ohid_next = cbyte;
                    opad_next = (state_reg == phe_pkg::ST_PAD);
                    oend_next = last_reg && (pos_inc == 4'd0);
                    collect_next[127 - pos_reg*8 -: 8] = cbyte;
                    pos_next  = pos_inc;
                    if (pos_inc == 4'd0) begin
                        chain_next = collect_next;
                    end
                    if (last_reg && pos_inc == 4'd0) begin
                        busy_next  = 1'b0;
                        chain_next = auth_reg;
                        state_next = phe_pkg::ST_IDLE;
                    end else if (last_reg) begin
                        byte_next  = 8'd0;
                        state_next = phe_pkg::ST_PAD;
                    end else begin
                        state_next = phe_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = phe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= phe_pkg::ST_IDLE;
            busy_reg       <= 1'b0;
            pos_reg        <= '0;
            ov_reg         <= 1'b0;
            chain_reg      <= '0;
            key_digest_reg <= '0;
            collect_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            pos_reg        <= pos_next;
            ov_reg         <= ov_next;
            chain_reg      <= chain_next;
            key_digest_reg <= key_digest_next;
            collect_reg    <= collect_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        byte_reg <= byte_next;
        ohid_reg <= ohid_next;
        opad_reg <= opad_next;
        oend_reg <= oend_next;
    end

    phe_md5_core u_md5 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .msg     (msg),
        .done    (hash_done),
        .digest  (hash_digest)
    );

    assign m_valid       = ov_reg;
    assign m_hidden_byte = ohid_reg;
    assign m_pad_flag    = opad_reg;
    assign m_end_flag    = oend_reg;

`include "password_hiding_engine_top_assert.svh"
    `PHE_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_ready, state_reg == phe_pkg::ST_IDLE, "ready outside idle")
    `PHE_ASSERT_IMPL(a_hash_done_state, aclk, aresetn, hash_done, state_reg == phe_pkg::ST_HASH, "digest done outside hash state")
    `PHE_ASSERT_NEXT(a_end_clears, aclk, aresetn, m_valid && m_ready && m_end_flag, !busy_reg, "password not closed after end item")
    `PHE_ASSERT_IMPL(a_pad_needs_last, aclk, aresetn, state_reg == phe_pkg::ST_PAD, last_reg, "padding without last byte")
endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the password hiding engine: directed and random passwords against an MD5 predictor.
`timescale 1ns / 1ps
module tb_top;
    // Index 7 is unmapped on the config port and must be ignored.
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    // Idle time at the end of each drain, longer than one MD5 hash.
    localparam int SETTLE_CYCLES = 100;
    // Cycles with no item moving on either channel before the run gives up.
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [7:0] hidden;
        logic       pad;
        logic       last;
    } hidden_item_t;

    // Holds a copy of the engine state and the queue of hidden bytes still to come.
    class hiding_scoreboard;
        logic [63:0]  secret_w[4];
        logic [5:0]   secret_len;
        logic [63:0]  auth_hi, auth_lo;
        logic [7:0]   chain[16];
        logic [7:0]   digest[16];
        logic [7:0]   collect[16];
        int           position;
        bit           in_password;
        hidden_item_t pending_q[$];
        int           mismatches;
        int           checked;
        int           pads_seen;
        int           blocks_hashed;
        bit [31:0]    round_k[64];
        int           round_s[16];

        function new();
            round_k = '{
                32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
            round_s = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            for (int i = 0; i < 4; i++) secret_w[i] = '0;
            secret_len = '0;
            auth_hi = '0;
            auth_lo = '0;
            for (int i = 0; i < 16; i++) begin
                chain[i] = '0;
                digest[i] = '0;
                collect[i] = '0;
            end
            position = 0;
            in_password = 0;
            mismatches = 0;
            checked = 0;
            pads_seen = 0;
            blocks_hashed = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                phe_pkg::REG_SECRET_0, phe_pkg::REG_SECRET_1,
                phe_pkg::REG_SECRET_2, phe_pkg::REG_SECRET_3: secret_w[idx[1:0]] = value;
                phe_pkg::REG_SECLEN: secret_len = value[5:0];
                phe_pkg::REG_AUTH_HI: auth_hi = value;
                phe_pkg::REG_AUTH_LO: auth_lo = value;
                default: ;
            endcase
        endfunction

        // One MD5 compression over secret || chain with padding and length.
        function void hash_block();
            logic [7:0]  msg[64];
            logic [31:0] m[16];
            logic [31:0] a, b, c, d, f, t, h0, h1, h2, h3;
            int          n, g;
            logic [63:0] bits;
            n = (secret_len > phe_pkg::SECRET_BYTES_HW) ? phe_pkg::SECRET_BYTES_HW
                                                        : int'(secret_len);
            for (int i = 0; i < 64; i++) msg[i] = '0;
            for (int i = 0; i < n; i++) msg[i] = secret_w[i / 8][63 - 8 * (i % 8) -: 8];
            for (int i = 0; i < 16; i++) msg[n + i] = chain[i];
            msg[n + 16] = 8'h80;
            bits = 64'(n + 16) * 8;
            for (int i = 0; i < 8; i++) msg[56 + i] = bits[8 * i +: 8];
            for (int i = 0; i < 16; i++)
                m[i] = {msg[4 * i + 3], msg[4 * i + 2], msg[4 * i + 1], msg[4 * i]};
            a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
            for (int i = 0; i < 64; i++) begin
                if (i < 16) begin
                    f = (b & c) | (~b & d); g = i;
                end else if (i < 32) begin
                    f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
                end else if (i < 48) begin
                    f = b ^ c ^ d; g = (3 * i + 5) % 16;
                end else begin
                    f = c ^ (b | ~d); g = (7 * i) % 16;
                end
                t = f + a + round_k[i] + m[g];
                a = d; d = c; c = b;
                b = b + ((t << round_s[(i / 16) * 4 + i % 4])
                        | (t >> (32 - round_s[(i / 16) * 4 + i % 4])));
            end
            h0 = 32'h67452301 + a;
            h1 = 32'hefcdab89 + b;
            h2 = 32'h98badcfe + c;
            h3 = 32'h10325476 + d;
            for (int i = 0; i < 4; i++) begin
                digest[i] = h0[8 * i +: 8];
                digest[4 + i] = h1[8 * i +: 8];
                digest[8 + i] = h2[8 * i +: 8];
                digest[12 + i] = h3[8 * i +: 8];
            end
            blocks_hashed++;
        endfunction

        function void hide_byte(logic [7:0] value, logic is_pad);
            hidden_item_t it;
            if (position == 0) hash_block();
            it.hidden = value ^ digest[position];
            it.pad = is_pad;
            it.last = 1'b0;
            collect[position] = it.hidden;
            pending_q.push_back(it);
            position = (position + 1) % 16;
            if (position == 0) chain = collect;
        endfunction

        // Note an accepted plaintext byte and queue every hidden byte it causes.
        function void note_input(logic [7:0] plain, logic last);
            if (!in_password) begin
                for (int j = 0; j < 8; j++) begin
                    chain[j] = auth_hi[63 - 8 * j -: 8];
                    chain[8 + j] = auth_lo[63 - 8 * j -: 8];
                end
                position = 0;
                in_password = 1;
            end
            hide_byte(plain, 1'b0);
            if (last) begin
                while (position != 0) hide_byte(8'h00, 1'b1);
                pending_q[$].last = 1'b1;
                in_password = 0;
            end
        endfunction

        function void check_result(logic [7:0] hidden, logic pad, logic last);
            hidden_item_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected hidden byte %02h pad %b end %b",
                             $realtime, hidden, pad, last);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (pad) pads_seen++;
            if (want.hidden !== hidden || want.pad !== pad || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp byte %02h pad %b end %b, got %02h %b %b",
                             $realtime, want.hidden, want.pad, want.last, hidden, pad, last);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_plain_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_hidden_byte;
    logic        m_pad_flag;
    logic        m_end_flag;

    hiding_scoreboard sb = new();
    int  sender_idle_pct = 0;
    int  receiver_idle_pct = 0;
    bit  hold_off = 0;
    int  items_sent = 0;
    int  passwords_sent = 0;
    int  quiet_cycles = 0;

    password_hiding_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_plain_byte(s_plain_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hidden_byte(m_hidden_byte), .m_pad_flag(m_pad_flag), .m_end_flag(m_end_flag)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: randomize ready, force it low during a hold-off, check each item taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_hidden_byte, m_pad_flag, m_end_flag);
        m_ready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: count cycles in which no item moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, sb.outstanding());
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hold cfg_we high across back-to-back writes; drop it with cfg_release.
    task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic cfg_release();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_config(logic [63:0] s0, logic [63:0] s1, logic [63:0] s2,
                               logic [63:0] s3, logic [5:0] len,
                               logic [63:0] ahi, logic [63:0] alo);
        cfg_write(phe_pkg::REG_SECRET_0, s0);
        cfg_write(phe_pkg::REG_SECRET_1, s1);
        cfg_write(phe_pkg::REG_SECRET_2, s2);
        cfg_write(phe_pkg::REG_SECRET_3, s3);
        cfg_write(phe_pkg::REG_SECLEN, len);
        cfg_write(phe_pkg::REG_AUTH_HI, ahi);
        cfg_write(phe_pkg::REG_AUTH_LO, alo);
        cfg_release();
    endtask

    task automatic load_random_config();
        logic [5:0] len;
        case ($urandom_range(3))
            0: len = 6'd0;
            1: len = 6'd32;
            2: len = 6'($urandom_range(63, 33));
            default: len = 6'($urandom_range(31, 1));
        endcase
        load_config(rand64(), rand64(), rand64(), rand64(), len, rand64(), rand64());
    endtask

    // Offer one item; keep valid high afterwards so the next item can follow directly.
    task automatic send_byte(logic [7:0] plain, logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_plain_byte <= plain;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(plain, last);
        items_sent++;
    endtask

    task automatic send_password(int len, int fixed_val);
        for (int i = 0; i < len; i++)
            send_byte((fixed_val < 0) ? 8'($urandom) : 8'(fixed_val), i == len - 1);
        passwords_sent++;
    endtask

    // Drop valid, drain every expected result, then let the engine settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_passwords(int item_budget);
        int start_items;
        int len;
        start_items = items_sent;
        while (items_sent - start_items < item_budget) begin
            // Mostly short passwords, a few spanning two or three blocks.
            len = ($urandom_range(9) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 1);
            send_password(len, -1);
            if ($urandom_range(5) == 0) begin
                drain();
                load_random_config();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: default all-zero config first, then the extremes of secret length.
        send_password(1, 8'h00);
        drain();
        load_config('1, '1, '1, '1, 6'd32, '1, '1);
        send_password(1, 8'hFF);
        send_password(16, 8'hFF);       // exact block: no pad bytes
        drain();
        load_config(rand64(), rand64(), rand64(), rand64(), 6'd63, '0, '1);
        send_password(17, 8'hA5);       // clamped secret length, one byte into block two
        drain();
        cfg_write(REG_UNMAPPED, '1);    // unmapped index must change nothing
        cfg_write(phe_pkg::REG_SECLEN, 6'd0);
        cfg_release();
        send_password(2, 8'h5A);
        drain();

        // Phase 1: sender rarely idles, receiver idles half the time.
        sender_idle_pct = 7;
        receiver_idle_pct = 51;
        load_random_config();
        random_passwords(100);
        drain();

        // Phase 2: roles swapped; hold the receiver off so the engine fills and stalls.
        sender_idle_pct = 51;
        receiver_idle_pct = 7;
        load_random_config();
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
        join_none
        random_passwords(100);
        drain();

        // Phase 3: full rate on both sides.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        load_random_config();
        random_passwords(100);
        drain();

        $display("covered %0d bytes in %0d passwords, %0d results checked (%0d pad bytes)",
                 items_sent, passwords_sent, sb.checked, sb.pads_seen);
        $display("%0d MD5 blocks predicted, %0d mismatches", sb.blocks_hashed, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
